>>> src/bts_pkg.sv
// Shared types and constants of the bilinear texture sampler.
// No dependencies; all other files but bts_ram refer to it by scoped names.
package bts_pkg;

    // Store geometry: square store of MAX_DIM x MAX_DIM texels, four parity banks.
    localparam int MAX_DIM = 256;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int BANK_AW = 2 * (IDX_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // Channel and texel widths.
    localparam int CH_W    = 16;
    localparam int TEXEL_W = 4 * CH_W;

    // Fixed-point formats.
    localparam int WF      = 8;
    localparam int CF      = 16;
    localparam int COORD_W = CF + 1;
    localparam int SIZE_W  = IDX_W + 1;
    localparam int PROD_W  = COORD_W + SIZE_W;
    localparam int BASE_W  = PROD_W - CF;
    localparam int WGT_W   = 2 * WF + 1;
    localparam int MUL_W   = CH_W + WGT_W;
    localparam int SUM_W   = MUL_W + 2;

    // Operation codes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
    localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LUM_MODE   = 2'd2;

    // Neighbor indices and upper-neighbor weights of both axes.
    typedef struct packed {
        logic [IDX_W-1:0] x0;
        logic [IDX_W-1:0] x1;
        logic [IDX_W-1:0] y0;
        logic [IDX_W-1:0] y1;
        logic [WF-1:0]    a;
        logic [WF-1:0]    b;
    } t_axis;

endpackage

>>> src/bts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bts_coord.sv
// Coordinate stages: scale by texture size, then offset, clamp and weight extraction.
// Depends on bts_pkg.
module bts_coord (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [bts_pkg::COORD_W-1:0] i_coord_u,
    input  logic [bts_pkg::COORD_W-1:0] i_coord_v,
    input  logic [bts_pkg::SIZE_W-1:0]  i_size_w,
    input  logic [bts_pkg::SIZE_W-1:0]  i_size_h,
    output bts_pkg::t_axis              o_axis
);

    localparam logic [bts_pkg::PROD_W-1:0] HALF = bts_pkg::PROD_W'(1) << (bts_pkg::CF - 1);

    logic [bts_pkg::PROD_W-1:0] r_pu, r_pv, n_pu, n_pv;
    logic [bts_pkg::SIZE_W-1:0] r_sw, r_sh;
    bts_pkg::t_axis             r_axis, n_axis;

    // Per-axis clamp-to-edge neighbor search.
    function automatic logic [2*bts_pkg::IDX_W+bts_pkg::WF-1:0] axis_f(
        input logic [bts_pkg::PROD_W-1:0] p,
        input logic [bts_pkg::SIZE_W-1:0] size
    );
        logic                         below;
        logic [bts_pkg::PROD_W-1:0]   s;
        logic [bts_pkg::BASE_W-1:0]   base;
        logic [bts_pkg::BASE_W:0]     base1;
        logic [bts_pkg::BASE_W-1:0]   lim;
        logic [bts_pkg::IDX_W-1:0]    i0, i1;
        logic [bts_pkg::WF-1:0]       w;
        below = p < HALF;
        s     = below ? p + HALF : p - HALF;
        w     = s[bts_pkg::CF-1 -: bts_pkg::WF];
        base  = s[bts_pkg::PROD_W-1:bts_pkg::CF];
        base1 = {1'b0, base} + 1'b1;
        lim   = bts_pkg::BASE_W'(size - 1'b1);
        if (below) begin
            i0 = '0;
            i1 = '0;
        end else begin
            i0 = (base > lim) ? lim[bts_pkg::IDX_W-1:0] : base[bts_pkg::IDX_W-1:0];
            i1 = (base1 > {1'b0, lim}) ? lim[bts_pkg::IDX_W-1:0]
                                       : base1[bts_pkg::IDX_W-1:0];
        end
        return {i0, i1, w};
    endfunction

    // Stage one: scale the normalized coordinates.
    assign n_pu = bts_pkg::PROD_W'(i_coord_u) * bts_pkg::PROD_W'(i_size_w);
    assign n_pv = bts_pkg::PROD_W'(i_coord_v) * bts_pkg::PROD_W'(i_size_h);

    // Stage two: neighbor indices and weights.
    always_comb begin
        {n_axis.x0, n_axis.x1, n_axis.a} = axis_f(r_pu, r_sw);
        {n_axis.y0, n_axis.y1, n_axis.b} = axis_f(r_pv, r_sh);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pu   <= n_pu;
            r_pv   <= n_pv;
            r_sw   <= i_size_w;
            r_sh   <= i_size_h;
            r_axis <= n_axis;
        end
    end

    assign o_axis = r_axis;

endmodule

>>> src/bts_blend.sv
// Blend stage: weighted channel products, registered, then summed and truncated.
// Depends on bts_pkg.
module bts_blend (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [bts_pkg::TEXEL_W-1:0] i_t00,
    input  logic [bts_pkg::TEXEL_W-1:0] i_t10,
    input  logic [bts_pkg::TEXEL_W-1:0] i_t01,
    input  logic [bts_pkg::TEXEL_W-1:0] i_t11,
    input  logic [bts_pkg::WGT_W-1:0]   i_w00,
    input  logic [bts_pkg::WGT_W-1:0]   i_w10,
    input  logic [bts_pkg::WGT_W-1:0]   i_w01,
    input  logic [bts_pkg::WGT_W-1:0]   i_w11,
    output logic [bts_pkg::CH_W-1:0]    o_res [4]
);

    logic [bts_pkg::MUL_W-1:0] r_m00 [4];
    logic [bts_pkg::MUL_W-1:0] r_m10 [4];
    logic [bts_pkg::MUL_W-1:0] r_m01 [4];
    logic [bts_pkg::MUL_W-1:0] r_m11 [4];
    logic [bts_pkg::SUM_W-1:0] sum [4];

    // One product per channel and neighbor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_m00[c] <= bts_pkg::MUL_W'(i_t00[c*bts_pkg::CH_W +: bts_pkg::CH_W]) *
                            bts_pkg::MUL_W'(i_w00);
                r_m10[c] <= bts_pkg::MUL_W'(i_t10[c*bts_pkg::CH_W +: bts_pkg::CH_W]) *
                            bts_pkg::MUL_W'(i_w10);
                r_m01[c] <= bts_pkg::MUL_W'(i_t01[c*bts_pkg::CH_W +: bts_pkg::CH_W]) *
                            bts_pkg::MUL_W'(i_w01);
                r_m11[c] <= bts_pkg::MUL_W'(i_t11[c*bts_pkg::CH_W +: bts_pkg::CH_W]) *
                            bts_pkg::MUL_W'(i_w11);
            end
        end
    end

    // Sum the four products and drop the weight fraction.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sum[c] = bts_pkg::SUM_W'(r_m00[c]) + bts_pkg::SUM_W'(r_m10[c]) +
                     bts_pkg::SUM_W'(r_m01[c]) + bts_pkg::SUM_W'(r_m11[c]);
            o_res[c] = sum[c][2*bts_pkg::WF +: bts_pkg::CH_W];
        end
    end

endmodule

>>> src/bilinear_texture_sampler.sv
// Top level of the bilinear texture sampler: config registers, pipeline control,
// banked texel store and output buffer. Depends on bts_pkg, bts_ram, bts_coord, bts_blend.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries either a texel write
// (operation 0) or a sample request (operation 1). A write stores one texel and
// returns nothing; a sample returns one filtered texel on the output channel
// (o_out_valid / i_out_ready). Items are taken one per cycle while o_in_ready is high.
// A sample passes the coordinate registers, the weight and bank read registers and
// the product registers into the output register. Throughput is one item per cycle
// while the skid register is empty, set by the five-stage pipeline and by the four
// parity banks of the texel store, which serve the four neighbor fetches in one read each.
// A write is visible to every sample accepted after it.
// Configuration goes through the APB port: width at 0x0, height at 0x4, luminance
// mode at 0x8. Write it only while the block is idle.
// Reset sets the size to 256 x 256 and RGBA mode and empties the pipeline; the
// texel store is not cleared and must be written before it is sampled.
// When the receiver stalls, the result waits in the output register and one more
// result goes to a skid register; the pipeline then halts until the skid drains.
module bilinear_texture_sampler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [bts_pkg::IDX_W-1:0]   i_texel_x,
    input  logic [bts_pkg::IDX_W-1:0]   i_texel_y,
    input  logic [bts_pkg::CH_W-1:0]    i_red_in,
    input  logic [bts_pkg::CH_W-1:0]    i_green_in,
    input  logic [bts_pkg::CH_W-1:0]    i_blue_in,
    input  logic [bts_pkg::CH_W-1:0]    i_alpha_in,
    input  logic [bts_pkg::COORD_W-1:0] i_coord_u,
    input  logic [bts_pkg::COORD_W-1:0] i_coord_v,
    // Output channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bts_pkg::CH_W-1:0]    o_red_out,
    output logic [bts_pkg::CH_W-1:0]    o_green_out,
    output logic [bts_pkg::CH_W-1:0]    o_blue_out,
    output logic [bts_pkg::CH_W-1:0]    o_alpha_out,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam logic [bts_pkg::SIZE_W-1:0] DIM = bts_pkg::SIZE_W'(bts_pkg::MAX_DIM);
    localparam logic [bts_pkg::WF:0]       W_ONE = (bts_pkg::WF+1)'(1) << bts_pkg::WF;

    // Configuration registers.
    logic [bts_pkg::SIZE_W-1:0] r_tex_width, r_tex_height;
    logic                       r_lum_mode;
    logic [bts_pkg::SIZE_W-1:0] eff_w, eff_h;
    logic [1:0]                 reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= DIM;
            r_tex_height <= DIM;
            r_lum_mode   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                bts_pkg::REG_TEX_WIDTH:  r_tex_width  <= pwdata[bts_pkg::SIZE_W-1:0];
                bts_pkg::REG_TEX_HEIGHT: r_tex_height <= pwdata[bts_pkg::SIZE_W-1:0];
                bts_pkg::REG_LUM_MODE:   r_lum_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (reg_idx)
            bts_pkg::REG_TEX_WIDTH:  prdata = 32'(r_tex_width);
            bts_pkg::REG_TEX_HEIGHT: prdata = 32'(r_tex_height);
            bts_pkg::REG_LUM_MODE:   prdata = 32'(r_lum_mode);
            default:                 prdata = '0;
        endcase
    end

    // Effective size: zero acts as one, oversize acts as the store size.
    assign eff_w = (r_tex_width == '0) ? bts_pkg::SIZE_W'(1) :
                   (r_tex_width > DIM) ? DIM : r_tex_width;
    assign eff_h = (r_tex_height == '0) ? bts_pkg::SIZE_W'(1) :
                   (r_tex_height > DIM) ? DIM : r_tex_height;

    // Pipeline control: every stage moves together unless the skid register is full.
    logic en;
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_op1, r_op2;
    logic r_out_v, r_skid_v;

    assign en         = !r_skid_v;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && (r_op2 == bts_pkg::OP_SAMPLE);
            r_v4 <= r_v3;
        end
    end

    // Write payload travels beside the coordinate stages.
    logic [bts_pkg::IDX_W-1:0]   r_tx1, r_ty1, r_tx2, r_ty2;
    logic [bts_pkg::TEXEL_W-1:0] r_td1, r_td2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op1 <= i_operation;
            r_tx1 <= i_texel_x;
            r_ty1 <= i_texel_y;
            r_td1 <= {i_alpha_in, i_blue_in, i_green_in, i_red_in};
            r_op2 <= r_op1;
            r_tx2 <= r_tx1;
            r_ty2 <= r_ty1;
            r_td2 <= r_td1;
        end
    end

    // Coordinate stages one and two.
    bts_pkg::t_axis ax;

    bts_coord u_coord (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_coord_u (i_coord_u),
        .i_coord_v (i_coord_v),
        .i_size_w  (eff_w),
        .i_size_h  (eff_h),
        .o_axis    (ax)
    );

    // Texel store in four banks by column and row parity.
    logic [bts_pkg::TEXEL_W-1:0] rd [4];
    logic                        do_write, do_read;

    assign do_write = en && r_v2 && (r_op2 == bts_pkg::OP_WRITE);
    assign do_read  = en && r_v2 && (r_op2 == bts_pkg::OP_SAMPLE);

    for (genvar bk = 0; bk < 4; bk++) begin : g_bank
        localparam logic PX = bk[1];
        localparam logic PY = bk[0];
        logic [bts_pkg::IDX_W-1:0]   xs, ys;
        logic [bts_pkg::BANK_AW-1:0] raddr, waddr;
        logic                        we;

        assign xs    = (ax.x0[0] == PX) ? ax.x0 : ax.x1;
        assign ys    = (ax.y0[0] == PY) ? ax.y0 : ax.y1;
        assign raddr = {ys[bts_pkg::IDX_W-1:1], xs[bts_pkg::IDX_W-1:1]};
        assign waddr = {r_ty2[bts_pkg::IDX_W-1:1], r_tx2[bts_pkg::IDX_W-1:1]};
        assign we    = do_write && (r_tx2[0] == PX) && (r_ty2[0] == PY);

        bts_ram #(
            .WIDTH (bts_pkg::TEXEL_W),
            .DEPTH (bts_pkg::BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (r_td2),
            .i_re    (do_read),
            .i_raddr (raddr),
            .o_rdata (rd[bk])
        );
    end

    // Stage three: bilinear weights and bank select bits beside the read.
    logic [bts_pkg::WGT_W-1:0] r_w00, r_w10, r_w01, r_w11;
    logic [bts_pkg::WF:0]      ia, ib, ja, jb;
    logic [1:0]                r_b00, r_b10, r_b01, r_b11;

    assign ia = W_ONE - (bts_pkg::WF+1)'(ax.a);
    assign ib = W_ONE - (bts_pkg::WF+1)'(ax.b);
    assign ja = (bts_pkg::WF+1)'(ax.a);
    assign jb = (bts_pkg::WF+1)'(ax.b);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w00 <= bts_pkg::WGT_W'(ia) * bts_pkg::WGT_W'(ib);
            r_w10 <= bts_pkg::WGT_W'(ja) * bts_pkg::WGT_W'(ib);
            r_w01 <= bts_pkg::WGT_W'(ia) * bts_pkg::WGT_W'(jb);
            r_w11 <= bts_pkg::WGT_W'(ja) * bts_pkg::WGT_W'(jb);
            r_b00 <= {ax.x0[0], ax.y0[0]};
            r_b10 <= {ax.x1[0], ax.y0[0]};
            r_b01 <= {ax.x0[0], ax.y1[0]};
            r_b11 <= {ax.x1[0], ax.y1[0]};
        end
    end

    // Stage four: products; stage five: sum into the output buffer.
    logic [bts_pkg::CH_W-1:0] res [4];

    bts_blend u_blend (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t00 (rd[r_b00]),
        .i_t10 (rd[r_b10]),
        .i_t01 (rd[r_b01]),
        .i_t11 (rd[r_b11]),
        .i_w00 (r_w00),
        .i_w10 (r_w10),
        .i_w01 (r_w01),
        .i_w11 (r_w11),
        .o_res (res)
    );

    // Luminance mode replicates the first channel.
    logic [4*bts_pkg::CH_W-1:0] n_pix;
    assign n_pix = r_lum_mode ? {4{res[0]}} : {res[3], res[2], res[1], res[0]};

    // Output register with one skid entry.
    logic [4*bts_pkg::CH_W-1:0] r_out, r_skid;
    logic                       take;

    assign take = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            // A new result always leaves the output register occupied.
            if (en && r_v4) begin
                r_out_v <= 1'b1;
            end else if (take && !r_skid_v) begin
                r_out_v <= 1'b0;
            end
            if (take && r_skid_v) begin
                r_skid_v <= 1'b0;
            end else if (en && r_v4 && r_out_v && !take) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_skid_v) begin
            r_out <= r_skid;
        end
        if (en && r_v4) begin
            if (!r_out_v || take) begin
                r_out <= n_pix;
            end else begin
                r_skid <= n_pix;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_red_out   = r_out[0*bts_pkg::CH_W +: bts_pkg::CH_W];
    assign o_green_out = r_out[1*bts_pkg::CH_W +: bts_pkg::CH_W];
    assign o_blue_out  = r_out[2*bts_pkg::CH_W +: bts_pkg::CH_W];
    assign o_alpha_out = r_out[3*bts_pkg::CH_W +: bts_pkg::CH_W];

    // The skid entry is only ever behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a result while the output register is empty");

    // The skid entry fills only when the receiver stalled a waiting result.
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_out_ready))
        else $error("skid register filled without a stall");

    // Neighbor columns and rows are equal or adjacent.
    a_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_op2 == bts_pkg::OP_SAMPLE) |->
        ((ax.x1 == ax.x0 || ax.x1 == ax.x0 + 1'b1) &&
         (ax.y1 == ax.y0 || ax.y1 == ax.y0 + 1'b1)))
        else $error("neighbor indices are not adjacent");

endmodule

>>> tb/sv/bilinear_texture_sampler_tb.sv
// Testbench of the bilinear texture sampler: texel writes and samples with random
// handshake gaps, results checked against a clamp-to-edge bilinear predictor.
// Depends on bts_pkg and bilinear_texture_sampler.
`timescale 1ns / 100ps

// Expected filtered texels, in order, with a checker for the output channel.
class texel_scoreboard;
    logic [63:0] texels[int];
    logic [8:0]  width = 9'd256;
    logic [8:0]  height = 9'd256;
    bit          lum = 1'b0;
    logic [63:0] pending[$];
    int          errors = 0;

    // Clamp-to-edge neighbors and upper weight along one axis.
    function void axis(input logic [16:0] coord, input logic [8:0] size_raw,
                       output int i0, output int i1, output int w);
        longint p, s, base, lim, sz;
        bit below;
        sz = (size_raw == 0) ? 1 : ((size_raw > 256) ? 256 : size_raw);
        p = longint'(coord) * sz;
        below = p < 32768;
        s = below ? p + 32768 : p - 32768;
        base = below ? 0 : (s >> 16);
        w = int'((s & 65535) >> 8);
        lim = sz - 1;
        i0 = below ? 0 : int'((base > lim) ? lim : base);
        i1 = below ? 0 : int'((base + 1 > lim) ? lim : base + 1);
    endfunction

    // Notes one accepted input transfer.
    function void note_input(input logic op, input logic [7:0] tx, input logic [7:0] ty,
                             input logic [63:0] texel, input logic [16:0] u,
                             input logic [16:0] v);
        int x0, x1, y0, y1, a, b, c;
        longint w00, w10, w01, w11, sum;
        logic [63:0] t00, t10, t01, t11, res;
        if (op == bts_pkg::OP_WRITE) begin
            texels[int'(ty) * 256 + int'(tx)] = texel;
            return;
        end
        axis(u, width, x0, x1, a);
        axis(v, height, y0, y1, b);
        t00 = texels[y0 * 256 + x0];
        t10 = texels[y0 * 256 + x1];
        t01 = texels[y1 * 256 + x0];
        t11 = texels[y1 * 256 + x1];
        w00 = (256 - a) * (256 - b);
        w10 = a * (256 - b);
        w01 = (256 - a) * b;
        w11 = a * b;
        for (c = 0; c < 4; c++) begin
            sum = longint'(t00[16*c +: 16]) * w00 + longint'(t10[16*c +: 16]) * w10 +
                  longint'(t01[16*c +: 16]) * w01 + longint'(t11[16*c +: 16]) * w11;
            res[16*c +: 16] = 16'(sum >> 16);
        end
        if (lum) res = {4{res[15:0]}};
        pending.push_back(res);
    endfunction

    // Checks one result transfer against the oldest expectation.
    function void check_result(input logic [63:0] got);
        logic [63:0] exp_t;
        string names[4];
        names = '{"red_out", "green_out", "blue_out", "alpha_out"};
        if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        exp_t = pending.pop_front();
        for (int c = 0; c < 4; c++)
            if (got[16*c +: 16] !== exp_t[16*c +: 16]) begin
                $error("%s expected %h actual %h", names[c], exp_t[16*c +: 16],
                       got[16*c +: 16]);
                errors++;
            end
    endfunction
endclass

module bilinear_texture_sampler_tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_operation = 1'b0;
    logic [7:0]  i_texel_x = '0, i_texel_y = '0;
    logic [15:0] i_red_in = '0, i_green_in = '0, i_blue_in = '0, i_alpha_in = '0;
    logic [16:0] i_coord_u = '0, i_coord_v = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_red_out, o_green_out, o_blue_out, o_alpha_out;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    texel_scoreboard sb = new();
    bit          sender_done = 1'b0;
    bit          quiet_sink = 1'b0;
    int          area_w = 1, area_h = 1;

    bilinear_texture_sampler u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Writes one register through a setup phase and an access phase.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            bts_pkg::REG_TEX_WIDTH:  sb.width = val[8:0];
            bts_pkg::REG_TEX_HEIGHT: sb.height = val[8:0];
            default:                 sb.lum = val[0];
        endcase
    endtask

    // Sends one input transfer after a random gap; valid drops only for a real gap.
    task automatic send_item(input logic op, input logic [7:0] tx, input logic [7:0] ty,
                             input logic [63:0] texel, input logic [16:0] u,
                             input logic [16:0] v, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : int'($urandom_range(0, 12));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1; i_operation <= op; i_texel_x <= tx; i_texel_y <= ty;
        {i_alpha_in, i_blue_in, i_green_in, i_red_in} <= texel;
        i_coord_u <= u; i_coord_v <= v;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(op, tx, ty, texel, u, v);
    endtask

    // Fills the texel area that samples can reach under the current size.
    task automatic fill_area(input int w, input int h);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                send_item(bts_pkg::OP_WRITE, 8'(x), 8'(y), {$urandom, $urandom},
                          17'($urandom), 17'($urandom), 1);
        area_w = w; area_h = h;
    endtask

    // Waits until every expected result has come, then for the pipeline to settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic random_sample();
        send_item(bts_pkg::OP_SAMPLE, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                  17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)));
    endtask

    // Output side: random stalls, quiet stretches, checks every result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_alpha_out, o_blue_out, o_green_out, o_red_out});
    end
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = quiet_sink ? 0 : int'($urandom_range(0, 12));
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Stimulus: directed extremes first, then random phases over several sizes.
    initial begin
        int sizes[6][2];
        sizes = '{'{1, 1}, '{256, 256}, '{2, 3}, '{7, 5}, '{16, 16}, '{256, 1}};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Full store corners, written at reset size 256 x 256.
        send_item(bts_pkg::OP_WRITE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 17'h1FFFF, 17'h1FFFF);
        send_item(bts_pkg::OP_WRITE, 1, 0, 64'h0, 0, 0);
        send_item(bts_pkg::OP_WRITE, 0, 1, 64'h1234_5678_9ABC_DEF0, 0, 0);
        send_item(bts_pkg::OP_WRITE, 1, 1, 64'hAAAA_5555_AAAA_5555, 0, 0);
        send_item(bts_pkg::OP_WRITE, 255, 255, 64'hFFFF_0000_FFFF_0000, 0, 0);
        send_item(bts_pkg::OP_WRITE, 254, 255, 64'h8000_8000_8000_8000, 0, 0);
        send_item(bts_pkg::OP_WRITE, 255, 254, 64'h0001_0002_0003_0004, 0, 0);
        send_item(bts_pkg::OP_WRITE, 254, 254, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        // Off-diagonal corners, reached when one axis sits low and the other high.
        send_item(bts_pkg::OP_WRITE, 255, 0, 64'h0F0F_F0F0_0F0F_F0F0, 0, 0);
        send_item(bts_pkg::OP_WRITE, 255, 1, 64'h7FFF_0001_7FFF_0001, 0, 0);
        send_item(bts_pkg::OP_WRITE, 0, 255, 64'hC000_3FFF_C000_3FFF, 0, 0);
        send_item(bts_pkg::OP_WRITE, 1, 255, 64'h0000_FFFF_1111_EEEE, 0, 0);
        // Low edge, interior and high edge / coordinates beyond one.
        send_item(bts_pkg::OP_SAMPLE, 8'hFF, 8'hFF, '1, 0, 0);
        send_item(bts_pkg::OP_SAMPLE, 0, 0, 0, 17'd200, 17'd300);
        send_item(bts_pkg::OP_SAMPLE, 0, 0, 0, 17'd383, 17'd383);
        send_item(bts_pkg::OP_SAMPLE, 0, 0, 0, 17'h0FFFF, 17'h0FFFF);
        send_item(bts_pkg::OP_SAMPLE, 0, 0, 0, 17'h1FFFF, 17'h1FFFF);
        send_item(bts_pkg::OP_SAMPLE, 0, 0, 0, 17'h0FF00, 17'h0FE80);
        drain();
        write_reg(bts_pkg::REG_LUM_MODE, 1);
        send_item(bts_pkg::OP_SAMPLE, 0, 0, 0, 17'd300, 17'd200);
        send_item(bts_pkg::OP_SAMPLE, 0, 0, 0, 17'h0FF00, 17'h1FFFF);
        drain();
        write_reg(bts_pkg::REG_TEX_WIDTH, 0);
        write_reg(bts_pkg::REG_TEX_HEIGHT, 511);
        send_item(bts_pkg::OP_SAMPLE, 0, 0, 0, 17'h10000, 17'd200);
        drain();
        // Random phases: refill reachable area, then mixed samples and writes.
        for (int ph = 0; ph < 6; ph++) begin
            int w, h;
            w = sizes[ph % 6][0]; h = sizes[ph % 6][1];
            write_reg(bts_pkg::REG_TEX_WIDTH, w);
            write_reg(bts_pkg::REG_TEX_HEIGHT, h);
            write_reg(bts_pkg::REG_LUM_MODE, $urandom_range(0, 1));
            quiet_sink = (ph == 4);
            if (w * h <= 256) fill_area(w, h);
            for (int n = 0; n < 145; n++) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(bts_pkg::OP_WRITE, 8'($urandom_range(0, area_w - 1)),
                              8'($urandom_range(0, area_h - 1)), {$urandom, $urandom},
                              17'($urandom), 17'($urandom));
                else if (w * h <= 256)
                    random_sample();
                else
                    // Large sizes only touch the directed corner texels.
                    send_item(bts_pkg::OP_SAMPLE, 8'($urandom), 8'($urandom),
                              {$urandom, $urandom},
                              17'($urandom_range(0, 1) ? $urandom_range(0, 383) :
                                  $urandom_range(130688, 131071)),
                              17'((h == 1 || $urandom_range(0, 1)) ? $urandom_range(0, 383) :
                                  $urandom_range(130688, 131071)));
                if (n == 50) drain();
            end
            drain();
        end
        sender_done = 1'b1;
    end

    // Final verdict once everything expected has arrived.
    initial begin
        wait (sender_done);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end
endmodule
